### rtl/ihpf_pkg.sv
// ----------------------------------------------------------------------------
// ihpf_pkg
// Shared types and constants of the IPv4 header parse and filter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihpf_pkg;

  // byte position saturates here, bytes at or past it are not captured
  localparam int POSITION_LIMIT = 2047;
  localparam int IDX_W          = $clog2(POSITION_LIMIT + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 184;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_IP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT = 2'd3;

  // verdict codes
  localparam logic [3:0] V_ACCEPT    = 4'd0;
  localparam logic [3:0] V_NOT_IPV4  = 4'd1;
  localparam logic [3:0] V_SRC_IP    = 4'd2;
  localparam logic [3:0] V_DST_IP    = 4'd3;
  localparam logic [3:0] V_FRAGMENT  = 4'd4;
  localparam logic [3:0] V_NOT_L4    = 4'd5;
  localparam logic [3:0] V_SRC_PORT  = 4'd6;
  localparam logic [3:0] V_DST_PORT  = 4'd7;
  localparam logic [3:0] V_TRUNC     = 4'd8;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;

  // which captured fields were fully received
  typedef struct packed {
    logic kind;
    logic src;
    logic dst;
    logic proto;
    logic ttl;
    logic len;
    logic frag;
    logic sport;
    logic dport;
    logic udp;
    logic tcp;
  } reach_t;

  // one frame's result as it leaves the parser
  typedef struct packed {
    logic [3:0]  verdict;
    logic [15:0] kind;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [7:0]  ttl;
    logic [15:0] len;
    logic [12:0] frag;
    logic [31:0] ports;
    logic [17:0] ulf;
    reach_t      reach;
  } rec_t;

endpackage

`default_nettype wire

### rtl/ihpf_parser.sv
// ----------------------------------------------------------------------------
// ihpf_parser
// Front end: counts byte positions, captures header fields, latches the
// first decided check result and emits one result request per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihpf_parser (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_fire,
  input  wire  [7:0]                       in_byte,
  input  wire                              in_last,
  input  wire                              cfg_we,
  input  wire  [ihpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [ihpf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                             rec_push,
  output ihpf_pkg::rec_t                   rec
);
  import ihpf_pkg::*;

  localparam logic [IDX_W-1:0] P_KIND_HI  = IDX_W'(12);
  localparam logic [IDX_W-1:0] P_KIND_LO  = IDX_W'(13);
  localparam logic [IDX_W-1:0] P_IHL      = IDX_W'(14);
  localparam logic [IDX_W-1:0] P_LEN_HI   = IDX_W'(16);
  localparam logic [IDX_W-1:0] P_LEN_LO   = IDX_W'(17);
  localparam logic [IDX_W-1:0] P_FRAG_HI  = IDX_W'(20);
  localparam logic [IDX_W-1:0] P_FRAG_LO  = IDX_W'(21);
  localparam logic [IDX_W-1:0] P_TTL      = IDX_W'(22);
  localparam logic [IDX_W-1:0] P_PROTO    = IDX_W'(23);
  localparam logic [IDX_W-1:0] P_SRC_0    = IDX_W'(26);
  localparam logic [IDX_W-1:0] P_SRC_3    = IDX_W'(29);
  localparam logic [IDX_W-1:0] P_DST_0    = IDX_W'(30);
  localparam logic [IDX_W-1:0] P_DST_3    = IDX_W'(33);
  localparam logic [IDX_W-1:0] N_ETH      = IDX_W'(14);
  localparam logic [IDX_W-1:0] N_IHL      = IDX_W'(15);
  localparam logic [IDX_W-1:0] N_LEN      = IDX_W'(18);
  localparam logic [IDX_W-1:0] N_FRAG     = IDX_W'(22);
  localparam logic [IDX_W-1:0] N_TTL      = IDX_W'(23);
  localparam logic [IDX_W-1:0] N_PROTO    = IDX_W'(24);
  localparam logic [IDX_W-1:0] N_SRC      = IDX_W'(30);
  localparam logic [IDX_W-1:0] N_DST      = IDX_W'(34);
  localparam logic [IDX_W-1:0] LIMIT      = IDX_W'(POSITION_LIMIT);

  function automatic logic ip_filter_on(input logic [31:0] m);
    ip_filter_on = (m[7:0] != 8'd0) && (m[15:8] != 8'd0) &&
                   (m[23:16] != 8'd0) && (m[31:24] != 8'd0);
  endfunction

  // configuration
  logic [31:0] src_ip_cfg_r, dst_ip_cfg_r;
  logic [15:0] src_port_cfg_r, dst_port_cfg_r;

  // per-frame control
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [5:0]       ihl_r, ihl_nxt;
  logic [3:0]       code_r, code_nxt;
  logic             decided_r, decided_nxt;

  // captures
  logic [15:0] kind_r, kind_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] ttl_proto_r, ttl_proto_nxt;
  logic [15:0] len_r, len_nxt;
  logic [12:0] frag_r, frag_nxt;
  logic [31:0] ports_r, ports_nxt;
  logic [17:0] ulf_r, ulf_nxt;

  logic [IDX_W-1:0] p, n, base;
  logic [5:0]       ihl_c;
  logic [3:0]       v, code_c;
  logic             decided_c;
  logic [7:0]       proto_c;

  always_comb begin
    p             = idx_r;
    ihl_c         = ihl_r;
    kind_nxt      = kind_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    ttl_proto_nxt = ttl_proto_r;
    len_nxt       = len_r;
    frag_nxt      = frag_r;
    ports_nxt     = ports_r;
    ulf_nxt       = ulf_r;
    n             = idx_r;

    if (in_fire && (p < LIMIT)) begin
      if (p == P_KIND_HI) kind_nxt[15:8] = in_byte;
      if (p == P_KIND_LO) kind_nxt[7:0]  = in_byte;
      if (p == P_IHL)     ihl_c          = {in_byte[3:0], 2'b00};
      if (p == P_LEN_HI)  len_nxt[15:8]  = in_byte;
      if (p == P_LEN_LO)  len_nxt[7:0]   = in_byte;
      if (p == P_FRAG_HI) frag_nxt[12:8] = in_byte[4:0];
      if (p == P_FRAG_LO) frag_nxt[7:0]  = in_byte;
      if (p == P_TTL)     ttl_proto_nxt[15:8] = in_byte;
      if (p == P_PROTO)   ttl_proto_nxt[7:0]  = in_byte;
      if (p >= P_SRC_0 && p <= P_SRC_3) src_nxt = {src_r[23:0], in_byte};
      if (p >= P_DST_0 && p <= P_DST_3) dst_nxt = {dst_r[23:0], in_byte};
      n = p + IDX_W'(1);
    end

    // l4 header starts right after the ip header, ihl taken this byte counts
    base = N_ETH + IDX_W'(ihl_c);

    if (in_fire && (p < LIMIT) && (p >= P_IHL)) begin
      if (p == base)                ports_nxt[31:24] = in_byte;
      if (p == base + IDX_W'(1))    ports_nxt[23:16] = in_byte;
      if (p == base + IDX_W'(2))    ports_nxt[15:8]  = in_byte;
      if (p == base + IDX_W'(3))    ports_nxt[7:0]   = in_byte;
      if (p == base + IDX_W'(4))    ulf_nxt[17:10]   = in_byte;
      if (p == base + IDX_W'(5))    ulf_nxt[9:2]     = in_byte;
      if (p == base + IDX_W'(13))   ulf_nxt[1:0]     = in_byte[1:0];
    end

    proto_c = ttl_proto_nxt[7:0];

    // ordered checks on what has been received so far
    if (n < N_ETH) begin
      v = V_TRUNC;
    end else if (kind_nxt != ETH_TYPE_IPV4) begin
      v = V_NOT_IPV4;
    end else if (n < N_SRC) begin
      v = V_TRUNC;
    end else if (ip_filter_on(src_ip_cfg_r) && src_nxt != src_ip_cfg_r) begin
      v = V_SRC_IP;
    end else if (n < N_DST) begin
      v = V_TRUNC;
    end else if (ip_filter_on(dst_ip_cfg_r) && dst_nxt != dst_ip_cfg_r) begin
      v = V_DST_IP;
    end else if (frag_nxt != 13'd0) begin
      v = V_FRAGMENT;
    end else if (proto_c != PROTO_UDP && proto_c != PROTO_TCP) begin
      v = V_NOT_L4;
    end else if (n < base + IDX_W'(2)) begin
      v = V_TRUNC;
    end else if (src_port_cfg_r != 16'd0 && ports_nxt[31:16] != src_port_cfg_r) begin
      v = V_SRC_PORT;
    end else if (n < base + IDX_W'(4)) begin
      v = V_TRUNC;
    end else if (dst_port_cfg_r != 16'd0 && ports_nxt[15:0] != dst_port_cfg_r) begin
      v = V_DST_PORT;
    end else if (proto_c == PROTO_UDP && n < base + IDX_W'(6)) begin
      v = V_TRUNC;
    end else if (proto_c == PROTO_TCP && n < base + IDX_W'(14)) begin
      v = V_TRUNC;
    end else begin
      v = V_ACCEPT;
    end

    code_c    = code_r;
    decided_c = decided_r;
    if (in_fire && !decided_r && v != V_TRUNC) begin
      code_c    = v;
      decided_c = 1'b1;
    end

    rec.verdict     = code_c;
    rec.kind        = kind_nxt;
    rec.src         = src_nxt;
    rec.dst         = dst_nxt;
    rec.proto       = ttl_proto_nxt[7:0];
    rec.ttl         = ttl_proto_nxt[15:8];
    rec.len         = len_nxt;
    rec.frag        = frag_nxt;
    rec.ports       = ports_nxt;
    rec.ulf         = ulf_nxt;
    rec.reach.kind  = n >= N_ETH;
    rec.reach.src   = n >= N_SRC;
    rec.reach.dst   = n >= N_DST;
    rec.reach.proto = n >= N_PROTO;
    rec.reach.ttl   = n >= N_TTL;
    rec.reach.len   = n >= N_LEN;
    rec.reach.frag  = n >= N_FRAG;
    rec.reach.sport = (n >= N_IHL) && (n >= base + IDX_W'(2));
    rec.reach.dport = (n >= N_IHL) && (n >= base + IDX_W'(4));
    rec.reach.udp   = (n >= N_PROTO) && (n >= base + IDX_W'(6));
    rec.reach.tcp   = (n >= N_PROTO) && (n >= base + IDX_W'(14));

    rec_push = in_fire && in_last;

    // end of frame returns the frame state to its start values
    if (rec_push) begin
      idx_nxt     = '0;
      ihl_nxt     = '0;
      code_nxt    = V_TRUNC;
      decided_nxt = 1'b0;
    end else begin
      idx_nxt     = n;
      ihl_nxt     = ihl_c;
      code_nxt    = code_c;
      decided_nxt = decided_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ip_cfg_r   <= '0;
      dst_ip_cfg_r   <= '0;
      src_port_cfg_r <= '0;
      dst_port_cfg_r <= '0;
      idx_r          <= '0;
      ihl_r          <= '0;
      code_r         <= V_TRUNC;
      decided_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_IP:   src_ip_cfg_r   <= cfg_wdata;
          CFG_DST_IP:   dst_ip_cfg_r   <= cfg_wdata;
          CFG_SRC_PORT: src_port_cfg_r <= cfg_wdata[15:0];
          CFG_DST_PORT: dst_port_cfg_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      idx_r     <= idx_nxt;
      ihl_r     <= ihl_nxt;
      code_r    <= code_nxt;
      decided_r <= decided_nxt;
    end
  end

  // captures are only reported once fully received in the current frame
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    ttl_proto_r <= ttl_proto_nxt;
    len_r       <= len_nxt;
    frag_r      <= frag_nxt;
    ports_r     <= ports_nxt;
    ulf_r       <= ulf_nxt;
  end

endmodule

`default_nettype wire

### rtl/ihpf_fifo.sv
// ----------------------------------------------------------------------------
// ihpf_fifo
// Two-entry result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihpf_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             wr_en,
  input  ihpf_pkg::rec_t  wr_data,
  output logic            full,
  input  wire             rd_en,
  output ihpf_pkg::rec_t  rd_data,
  output logic            empty
);
  import ihpf_pkg::*;

  rec_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  always_comb begin
    full    = count_r == 2'd2;
    empty   = count_r == 2'd0;
    do_wr   = wr_en && !full;
    do_rd   = rd_en && !empty;
    rd_data = mem_r[rd_ptr_r];

    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/ihpf_emit.sv
// ----------------------------------------------------------------------------
// ihpf_emit
// Back end: zeroes fields that were not reached, packs the result and holds
// it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihpf_emit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  ihpf_pkg::rec_t                      rec,
  input  wire                                 rec_empty,
  output logic                                rec_pop,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [ihpf_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import ihpf_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic [15:0]           kind_o, len_o, frag_o, sport_o, dport_o, udp_o;
  logic [31:0]           src_o, dst_o;
  logic [7:0]            proto_o, ttl_o;
  logic [1:0]            flags_o;

  always_comb begin
    kind_o  = rec.reach.kind  ? rec.kind : 16'd0;
    src_o   = rec.reach.src   ? rec.src  : 32'd0;
    dst_o   = rec.reach.dst   ? rec.dst  : 32'd0;
    proto_o = rec.reach.proto ? rec.proto : 8'd0;
    ttl_o   = rec.reach.ttl   ? rec.ttl  : 8'd0;
    len_o   = rec.reach.len   ? rec.len  : 16'd0;
    frag_o  = rec.reach.frag  ? {rec.frag, 3'b000} : 16'd0;
    sport_o = rec.reach.sport ? rec.ports[31:16] : 16'd0;
    dport_o = rec.reach.dport ? rec.ports[15:0]  : 16'd0;
    udp_o   = (rec.reach.udp && rec.proto == PROTO_UDP) ? rec.ulf[17:2] : 16'd0;
    flags_o = (rec.reach.tcp && rec.proto == PROTO_TCP) ? rec.ulf[1:0]  : 2'd0;

    rec_pop = !rec_empty && (!valid_r || out_tready);

    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (rec_pop) begin
      valid_nxt = 1'b1;
      data_nxt  = {2'b00, flags_o, udp_o, dport_o, sport_o, frag_o, len_o,
                   ttl_o, proto_o, dst_o, src_o, kind_o, rec.verdict};
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end

    out_tvalid = valid_r;
    out_tdata  = data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

### rtl/ipv4_header_parse_filter.sv
// ----------------------------------------------------------------------------
// ipv4_header_parse_filter
// Byte-wide Ethernet frame parser with an IPv4 five-tuple filter verdict.
// ----------------------------------------------------------------------------
// Input stream: one frame byte per request on in_tdata, in_tlast on the final
// byte (CRC already stripped). The input takes one byte per cycle whenever
// the two-entry result queue has room.
// Output stream: one request per frame carrying the verdict and the captured
// header fields. A frame's result enters the result queue when its last byte
// is accepted, moves to the output register and holds until out_tready is high.
// Throughput is one byte per cycle; the per-byte path is a position compare
// and a field capture in the parser. A stalled receiver first fills the
// output register and the queue; in_tready then drops until a result leaves.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 source ip, 1 destination ip, 2 source port, 3 destination port); write
// only while no frame is in flight.
// Reset (rst_n low, synchronous) clears filters, frame state, queue and
// output valid; no initialization pass follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv4_header_parse_filter (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [7:0]                         in_tdata,   // frame_byte
  input  wire                                in_tlast,   // end_of_frame
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // verdict, ether_kind, ip_source, ip_dest, ip_proto, time_to_live,
  // ip_total_length, fragment_bytes, port_source, port_dest, udp_len,
  // syn_fin_flags, zero pad
  output logic [ihpf_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                                cfg_we,
  input  wire  [ihpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ihpf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ihpf_pkg::*;

  logic in_fire;
  logic rec_push, rec_pop, q_full, q_empty;
  rec_t rec_in, rec_out;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  ihpf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  ihpf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .full    (q_full),
    .rd_en   (rec_pop),
    .rd_data (rec_out),
    .empty   (q_empty)
  );

  ihpf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec        (rec_out),
    .rec_empty  (q_empty),
    .rec_pop    (rec_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### rtl/ihpf_checker.sv
// ----------------------------------------------------------------------------
// ihpf_checker
// Port-level checks on the result stream of the parse and filter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihpf_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  input  wire [ihpf_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import ihpf_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= V_TRUNC)
    else $error("verdict code out of range");

  // an accepted frame must be ipv4 carrying tcp or udp
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] == V_ACCEPT |->
      out_tdata[19:4] == ETH_TYPE_IPV4 &&
      (out_tdata[91:84] == PROTO_UDP || out_tdata[91:84] == PROTO_TCP))
    else $error("accepted frame is not ipv4 tcp or udp");

  // fragment verdict needs a nonzero offset
  a_frag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] == V_FRAGMENT |-> out_tdata[131:116] != 16'd0)
    else $error("fragment verdict with zero offset");

endmodule

bind ipv4_header_parse_filter ihpf_checker u_ihpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
